// ===== sv/sorted_linked_slot_queue_defines.svh =====
// assertion macros for the sorted linked slot queue
`ifndef SORTED_LINKED_SLOT_QUEUE_DEFINES_SVH
`define SORTED_LINKED_SLOT_QUEUE_DEFINES_SVH
`ifndef SYNTH
`define SLQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slq assertion failed");
`define SLQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slq assertion failed");
`else
`define SLQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SLQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/slq_pkg.sv =====
// shared types and constants of the sorted linked slot queue
`default_nettype none
package slq_pkg;
    localparam int SLOTS_DEF        = 16;
    localparam int KEY_BITS_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int KEY_W            = 64;
    localparam int PAY_W            = 32;
    localparam int CNT_W            = 5;
    localparam logic OP_INSERT      = 1'b0;
    localparam logic OP_REMOVE      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_I_CMP,
        ST_I_WALK,
        ST_I_WR,
        ST_R_DATA,
        ST_R_LNK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        INS_EMPTY,
        INS_FRONT,
        INS_TAIL,
        INS_MID
    } ins_case_t;
endpackage
`default_nettype wire

// ===== sv/slq_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module slq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== sv/sorted_linked_slot_queue.sv =====
// insert: accept, head read and compare, a walk over the entries in key order, then
// 2 or 3 link writes and the result (one write into an empty list); the free slot scan
// runs beside the walk and holds the writes until it lands on a free slot
// remove: tail read, then a read-modify-write of the predecessor's link if there is one
// rejected items skip to the result; one item is worked at a time, result held in an output reg
// reset (aresetn low, synchronous) empties the pool at once; ram contents need no clearing
`default_nettype none
`include "sorted_linked_slot_queue_defines.svh"
module sorted_linked_slot_queue
    import slq_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_op,
    input  wire logic [KEY_W-1:0] s_key_in,
    input  wire logic [PAY_W-1:0] s_payload_in,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_ok,
    output logic [KEY_W-1:0]      m_key_out,
    output logic [PAY_W-1:0]      m_payload_out,
    output logic [CNT_W-1:0]      m_entry_count
);
    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int KW = KEY_BITS;
    localparam int PW = PAYLOAD_BITS;
    localparam int DW = KW + PW;
    localparam int NW = 2 * LW;
    localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

    // control state
    state_t            state_reg, state_next;
    ins_case_t         case_reg, case_next;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [LW-1:0]     count_reg, count_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic [LW-1:0]     step_reg, step_next;
    logic [1:0]        wr_reg, wr_next;
    logic              m_valid_reg, m_valid_next;

    // item and walk data
    logic [KW-1:0]     key_reg, key_next;
    logic [PW-1:0]     pay_reg, pay_next;
    logic [IW-1:0]     before_reg, before_next;
    logic [IW-1:0]     after_reg, after_next;
    logic [NW-1:0]     bef_lnk_reg, bef_lnk_next;
    logic [NW-1:0]     aft_lnk_reg, aft_lnk_next;
    logic              res_ok_reg, res_ok_next;
    logic [KW-1:0]     res_key_reg, res_key_next;
    logic [PW-1:0]     res_pay_reg, res_pay_next;
    logic              m_ok_reg, m_ok_next;
    logic [KW-1:0]     m_key_reg, m_key_next;
    logic [PW-1:0]     m_pay_reg, m_pay_next;
    logic [LW-1:0]     m_cnt_reg, m_cnt_next;

    // ram ports
    logic [IW-1:0]     rd_addr;
    logic              kp_we;
    logic [IW-1:0]     kp_waddr;
    logic [DW-1:0]     kp_wdata;
    logic [DW-1:0]     kp_rdata;
    logic              ln_we;
    logic [IW-1:0]     ln_waddr;
    logic [NW-1:0]     ln_wdata;
    logic [NW-1:0]     ln_rdata;

    // field views
    logic [KW-1:0]     rd_key;
    logic [LW-1:0]     rd_next;
    logic [LW-1:0]     rd_prev;
    logic [LW-1:0]     slot_link;
    logic [63:0]       pay_in_ext;
    logic [63:0]       m_pay_ext;
    logic [LW+CNT_W-1:0] m_cnt_ext;

    assign rd_key     = kp_rdata[DW-1:PW];
    assign rd_next    = ln_rdata[NW-1:LW];
    assign rd_prev    = ln_rdata[LW-1:0];
    assign slot_link  = LW'(scan_reg);
    assign pay_in_ext = 64'(s_payload_in);

    // key and payload store
    slq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_kp_ram (
        .clk   (aclk),
        .we    (kp_we),
        .waddr (kp_waddr),
        .wdata (kp_wdata),
        .raddr (rd_addr),
        .rdata (kp_rdata)
    );

    // link store, {next, prev} per slot
    slq_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_ln_ram (
        .clk   (aclk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .raddr (rd_addr),
        .rdata (ln_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            head_reg    <= IW'(SLOTS - 1);
            tail_reg    <= IW'(SLOTS - 1);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        case_reg    <= case_next;
        scan_reg    <= scan_next;
        step_reg    <= step_next;
        wr_reg      <= wr_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
        bef_lnk_reg <= bef_lnk_next;
        aft_lnk_reg <= aft_lnk_next;
        res_ok_reg  <= res_ok_next;
        res_key_reg <= res_key_next;
        res_pay_reg <= res_pay_next;
        m_ok_reg    <= m_ok_next;
        m_key_reg   <= m_key_next;
        m_pay_reg   <= m_pay_next;
        m_cnt_reg   <= m_cnt_next;
    end

    always_comb begin
        logic ins_done;
        ins_done     = 1'b0;
        state_next   = state_reg;
        case_next    = case_reg;
        used_next    = used_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        wr_next      = wr_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        before_next  = before_reg;
        after_next   = after_reg;
        bef_lnk_next = bef_lnk_reg;
        aft_lnk_next = aft_lnk_reg;
        res_ok_next  = res_ok_reg;
        res_key_next = res_key_reg;
        res_pay_next = res_pay_reg;
        m_ok_next    = m_ok_reg;
        m_key_next   = m_key_reg;
        m_pay_next   = m_pay_reg;
        m_cnt_next   = m_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        rd_addr      = head_reg;
        kp_we        = 1'b0;
        kp_waddr     = scan_reg;
        kp_wdata     = {key_reg, pay_reg};
        ln_we        = 1'b0;
        ln_waddr     = scan_reg;
        ln_wdata     = {LINK_NONE, LINK_NONE};
        // free slot scan runs down from the top while the walk goes on
        scan_next    = used_reg[scan_reg] ? scan_reg - IW'(1) : scan_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    key_next     = KW'(s_key_in);
                    pay_next     = pay_in_ext[PW-1:0];
                    scan_next    = IW'(SLOTS - 1);
                    step_next    = '0;
                    wr_next      = '0;
                    res_ok_next  = 1'b0;
                    res_key_next = '0;
                    res_pay_next = '0;
                    if (s_op == OP_INSERT) begin
                        if (count_reg == LW'(SLOTS)) begin
                            state_next = ST_DONE;
                        end else if (!used_reg[head_reg]) begin
                            case_next  = INS_EMPTY;
                            state_next = ST_I_WR;
                        end else begin
                            rd_addr    = head_reg;
                            state_next = ST_I_CMP;
                        end
                    end else begin
                        if (!used_reg[tail_reg]) begin
                            state_next = ST_DONE;
                        end else begin
                            rd_addr    = tail_reg;
                            state_next = ST_R_DATA;
                        end
                    end
                end
            end
            ST_I_CMP: begin
                bef_lnk_next = ln_rdata;
                if (rd_key > key_reg) begin
                    case_next  = INS_FRONT;
                    state_next = ST_I_WR;
                end else begin
                    before_next = head_reg;
                    if (rd_next >= LINK_NONE) begin
                        case_next  = INS_TAIL;
                        state_next = ST_I_WR;
                    end else begin
                        after_next = rd_next[IW-1:0];
                        rd_addr    = rd_next[IW-1:0];
                        state_next = ST_I_WALK;
                    end
                end
            end
            ST_I_WALK: begin
                if (rd_key < key_reg && step_reg < LW'(SLOTS)) begin
                    before_next  = after_reg;
                    bef_lnk_next = ln_rdata;
                    step_next    = step_reg + LW'(1);
                    if (rd_next >= LINK_NONE) begin
                        case_next  = INS_TAIL;
                        state_next = ST_I_WR;
                    end else begin
                        after_next = rd_next[IW-1:0];
                        rd_addr    = rd_next[IW-1:0];
                    end
                end else begin
                    aft_lnk_next = ln_rdata;
                    case_next    = INS_MID;
                    state_next   = ST_I_WR;
                end
            end
            ST_I_WR: begin
                // wait for the scan to land on a free slot
                if (!used_reg[scan_reg]) begin
                    unique case (wr_reg)
                        2'd0: begin
                            kp_we    = 1'b1;
                            ln_we    = 1'b1;
                            ln_waddr = scan_reg;
                            unique case (case_reg)
                                INS_EMPTY: ln_wdata = {LINK_NONE, LINK_NONE};
                                INS_FRONT: ln_wdata = {LW'(head_reg), LINK_NONE};
                                INS_TAIL:  ln_wdata = {LINK_NONE, LW'(before_reg)};
                                INS_MID:   ln_wdata = {LW'(after_reg), LW'(before_reg)};
                                default:   ln_wdata = {LINK_NONE, LINK_NONE};
                            endcase
                            if (case_reg == INS_EMPTY) begin
                                ins_done = 1'b1;
                            end else begin
                                wr_next = 2'd1;
                            end
                        end
                        2'd1: begin
                            ln_we = 1'b1;
                            if (case_reg == INS_FRONT) begin
                                ln_waddr = head_reg;
                                ln_wdata = {bef_lnk_reg[NW-1:LW], slot_link};
                                ins_done = 1'b1;
                            end else begin
                                ln_waddr = before_reg;
                                ln_wdata = {slot_link, bef_lnk_reg[LW-1:0]};
                                if (case_reg == INS_MID) begin
                                    wr_next = 2'd2;
                                end else begin
                                    ins_done = 1'b1;
                                end
                            end
                        end
                        default: begin
                            ln_we    = 1'b1;
                            ln_waddr = after_reg;
                            ln_wdata = {aft_lnk_reg[NW-1:LW], slot_link};
                            ins_done = 1'b1;
                        end
                    endcase
                    if (ins_done) begin
                        used_next[scan_reg] = 1'b1;
                        count_next          = count_reg + LW'(1);
                        res_ok_next         = 1'b1;
                        scan_next           = scan_reg;
                        state_next          = ST_DONE;
                        unique case (case_reg)
                            INS_EMPTY: begin
                                head_next = scan_reg;
                                tail_next = scan_reg;
                            end
                            INS_FRONT: head_next = scan_reg;
                            INS_TAIL:  tail_next = scan_reg;
                            default:   head_next = head_reg;
                        endcase
                    end
                end
            end
            ST_R_DATA: begin
                res_ok_next         = 1'b1;
                res_key_next        = rd_key;
                res_pay_next        = kp_rdata[PW-1:0];
                used_next[tail_reg] = 1'b0;
                count_next          = count_reg - LW'(1);
                if (rd_prev < LINK_NONE) begin
                    tail_next  = rd_prev[IW-1:0];
                    rd_addr    = rd_prev[IW-1:0];
                    state_next = ST_R_LNK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_R_LNK: begin
                // new tail loses its successor
                ln_we      = 1'b1;
                ln_waddr   = tail_reg;
                ln_wdata   = {LINK_NONE, rd_prev};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_key_next   = res_key_reg;
                    m_pay_next   = res_pay_reg;
                    m_cnt_next   = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_pay_ext     = 64'(m_pay_reg);
    assign m_cnt_ext     = (LW + CNT_W)'(m_cnt_reg);
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_key_out     = KEY_W'(m_key_reg);
    assign m_payload_out = m_pay_ext[PAY_W-1:0];
    assign m_entry_count = m_cnt_ext[CNT_W-1:0];

    `SLQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= LW'(SLOTS))
    `SLQ_ASSERT_IMP(a_head_tail_agree, aclk, aresetn, state_reg == ST_IDLE,
                    used_reg[head_reg] == used_reg[tail_reg])
    `SLQ_ASSERT_NXT(a_full_reject, aclk, aresetn,
                    s_valid && s_ready && s_op == OP_INSERT && count_reg == LW'(SLOTS),
                    state_reg == ST_DONE && !res_ok_reg)
    `SLQ_ASSERT_IMP(a_walk_bound, aclk, aresetn, state_reg == ST_I_WALK,
                    step_reg <= LW'(SLOTS))
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the sorted linked slot queue
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import slq_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NONE = NSLOT;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] count;
    } rsp_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_op = OP_INSERT;
    logic [KEY_W-1:0] s_key_in = '0;
    logic [PAY_W-1:0] s_payload_in = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_ok;
    logic [KEY_W-1:0] m_key_out;
    logic [PAY_W-1:0] m_payload_out;
    logic [CNT_W-1:0] m_entry_count;

    sorted_linked_slot_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_key_in(s_key_in), .s_payload_in(s_payload_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_key_out(m_key_out), .m_payload_out(m_payload_out),
        .m_entry_count(m_entry_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the slot pool
    logic             pool_used [NSLOT];
    logic [KEY_W-1:0] pool_key  [NSLOT];
    logic [PAY_W-1:0] pool_pay  [NSLOT];
    int               pool_next [NSLOT];
    int               pool_prev [NSLOT];
    int               head_slot, tail_slot, occupied;

    req_t pending_items[$];
    rsp_t expected_results[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   inserts_ok = 0, removes_ok = 0, rejects = 0, max_fill = 0;
    int   cycles = 0;
    bit   stim_done = 0;
    bit   long_stall = 0;

    function automatic void pool_clear();
        for (int s = 0; s < NSLOT; s++) pool_used[s] = 1'b0;
        head_slot = NSLOT - 1;
        tail_slot = NSLOT - 1;
        occupied = 0;
    endfunction

    // sorted insert / tail pop, producing the expected result
    function automatic rsp_t queue_apply(req_t r);
        rsp_t o;
        int fr, b, a, n;
        o = '0;
        if (r.op == OP_INSERT) begin
            fr = NONE;
            for (int s = NSLOT - 1; s >= 0; s--)
                if (!pool_used[s] && fr == NONE) fr = s;
            if (fr != NONE) begin
                pool_key[fr] = r.key;
                pool_pay[fr] = r.payload;
                if (!pool_used[head_slot]) begin
                    head_slot = fr; tail_slot = fr;
                    pool_next[fr] = NONE; pool_prev[fr] = NONE;
                end else if (pool_key[head_slot] > r.key) begin
                    pool_next[fr] = head_slot; pool_prev[fr] = NONE;
                    pool_prev[head_slot] = fr; head_slot = fr;
                end else begin
                    b = head_slot; a = pool_next[head_slot]; n = 0;
                    while (a < NSLOT && pool_key[a] < r.key && n < NSLOT) begin
                        b = a; a = pool_next[a]; n++;
                    end
                    pool_next[b] = fr; pool_prev[fr] = b;
                    if (a >= NSLOT) begin
                        pool_next[fr] = NONE; tail_slot = fr;
                    end else begin
                        pool_next[fr] = a; pool_prev[a] = fr;
                    end
                end
                pool_used[fr] = 1'b1;
                occupied++;
                o.ok = 1'b1;
            end
        end else if (pool_used[tail_slot]) begin
            o.ok = 1'b1;
            o.key = pool_key[tail_slot];
            o.payload = pool_pay[tail_slot];
            pool_used[tail_slot] = 1'b0;
            occupied--;
            if (pool_prev[tail_slot] < NSLOT) begin
                tail_slot = pool_prev[tail_slot];
                pool_next[tail_slot] = NONE;
            end
        end
        o.count = occupied[CNT_W-1:0];
        return o;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        // narrow keys make equal keys common, wide ones reach every bit
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 7));
            1: return {$urandom(), $urandom()};
            2: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom()};
            default: return KEY_W'($urandom_range(0, 255)) << $urandom_range(0, 56);
        endcase
    endfunction

    function automatic req_t make_item(logic op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        req_t r;
        r.op = op; r.key = k; r.payload = p;
        return r;
    endfunction

    // directed part, then random bursts biased toward fill or drain
    initial begin
        int bias;
        pool_clear();
        pending_items.push_back(make_item(OP_REMOVE, '0, '0));          // remove from empty
        pending_items.push_back(make_item(OP_INSERT, '1, '1));
        pending_items.push_back(make_item(OP_INSERT, '0, '0));          // new head
        pending_items.push_back(make_item(OP_INSERT, 64'h5, 32'hA5A5_A5A5));
        pending_items.push_back(make_item(OP_INSERT, 64'h5, 32'h5A5A_5A5A)); // equal keys
        pending_items.push_back(make_item(OP_INSERT, '0, 32'h1));       // equal to head
        for (int i = 0; i < 12; i++)                                  // fill to the top
            pending_items.push_back(make_item(OP_INSERT, KEY_W'(i * 3), PAY_W'(i)));
        pending_items.push_back(make_item(OP_INSERT, 64'h7, 32'h7));    // pool full
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(OP_REMOVE, rand_key(), $urandom()));
        for (int i = 0; i < 850; i++) begin
            if (i % 40 == 0) bias = $urandom_range(20, 80);
            pending_items.push_back(make_item($urandom_range(0, 99) < bias ? OP_INSERT
                                              : OP_REMOVE, rand_key(), $urandom()));
        end
    end

    // reset and cycle count
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == 9) aresetn <= 1'b1;
    end

    // driver: random gap per item, valid held until accepted
    int send_gap = 0;
    always @(posedge aclk) begin
        rsp_t pred;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred = queue_apply(make_item(s_op, s_key_in, s_payload_in));
                expected_results.push_back(pred);
                if (pred.ok && s_op == OP_INSERT) inserts_ok++;
                else if (pred.ok) removes_ok++;
                pending_items.pop_front();
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            end
            if ((s_valid && !s_ready) || (!s_valid && send_gap == 0 &&
                    pending_items.size() > 0) ||
                    (s_valid && s_ready && send_gap == 0 && pending_items.size() > 0)) begin
                if (!(s_valid && !s_ready)) begin
                    s_op <= pending_items[0].op;
                    s_key_in <= pending_items[0].key;
                    s_payload_in <= pending_items[0].payload;
                end
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
            if (pending_items.size() == 0 && !s_valid) stim_done <= 1'b1;
        end
    end

    // receiver hold-off: one long stall while the sender keeps pushing
    int stall_left = 0;
    always @(posedge aclk) begin
        if (results_seen == 300 && !long_stall) begin
            long_stall <= 1'b1;
            stall_left <= 600;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // monitor: compare every result with the oldest expectation
    int recv_gap = 0;
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
                end else begin
                    want = expected_results.pop_front();
                    if (!want.ok) rejects++;
                    if (int'(want.count) > max_fill) max_fill = want.count;
                    if (m_ok !== want.ok || m_key_out !== want.key ||
                            m_payload_out !== want.payload || m_entry_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp ok=%b key=%h pay=%h cnt=%0d,",
                                     want.ok, want.key, want.payload, want.count,
                                     " got ok=%b key=%h pay=%h cnt=%0d",
                                     m_ok, m_key_out, m_payload_out, m_entry_count);
                    end
                end
                recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0 || recv_gap > 0) begin
                m_ready <= 1'b0;
                if (recv_gap > 0) recv_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // end of run: drain, settle, report
    initial begin
        wait (stim_done && expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        $display("%0d results checked: %0d inserts, %0d removes, %0d rejected (full or empty)",
                 results_seen, inserts_ok, removes_ok, rejects);
        $display("peak fill %0d of %0d slots, with one long receiver hold-off", max_fill, NSLOT);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
